FILE: hw/rtl/abm_pkg.sv
// ============================================================================
// abm_pkg - shared types and constants of the burst memory slave
// Memory geometry, queue operation word and small helper functions.
// ============================================================================
package abm_pkg;

    localparam int MEM_WORDS   = 65536;
    localparam int MAX_BEATS   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int MEM_AW  = $clog2(MEM_WORDS);
    localparam int BEAT_W  = $clog2(MAX_BEATS + 1);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    // input command codes
    localparam logic [1:0] CMD_READ_REQ  = 2'd0;
    localparam logic [1:0] CMD_WRITE_REQ = 2'd1;
    localparam logic [1:0] CMD_WRITE_DAT = 2'd2;

    // result kinds
    localparam logic KIND_READ_DATA = 1'b0;
    localparam logic KIND_WRITE_RSP = 1'b1;

    // back-end operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [31:0]       addr;
        logic [31:0]       data;
        logic [BEAT_W-1:0] count;
        logic [1:0]        size;
        logic              resp;
    } abm_op_t;

    function automatic logic [BEAT_W-1:0] beat_count(input logic [3:0] len);
        logic [4:0] n;
        n = {1'b0, len} + 5'd1;
        if (int'(n) > MAX_BEATS)
            return BEAT_W'(MAX_BEATS);
        return BEAT_W'(n);
    endfunction

    function automatic logic word_in_range(input logic [31:0] mem_addr);
        return mem_addr[31:2] < 30'(MEM_WORDS);
    endfunction

endpackage

FILE: hw/rtl/abm_if.sv
// ============================================================================
// abm_if - request and response channels of the burst memory slave
// Valid/ready channels; a word moves when valid and ready are both high.
// ============================================================================
interface abm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] address;
    logic [3:0]  burst_len;
    logic [1:0]  beat_size;
    logic [31:0] write_data;

    modport source (output valid, command, address, burst_len, beat_size, write_data,
                    input ready);
    modport sink   (input valid, command, address, burst_len, beat_size, write_data,
                    output ready);
endinterface

interface abm_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] read_data;
    logic        last;

    modport source (output valid, kind, read_data, last, input ready);
    modport sink   (input valid, kind, read_data, last, output ready);
endinterface

FILE: hw/rtl/abm_front.sv
// ============================================================================
// abm_front - request front end
// Accepts request words, tracks the open write burst and queues operations.
// ============================================================================
module abm_front (
    input  logic             clk,
    input  logic             rst_n,
    abm_in_if.sink           request,
    input  logic             clear_done,
    output logic             push_valid,
    output abm_pkg::abm_op_t push_op,
    input  logic             push_ready
);

    logic                      write_open_reg, write_open_next;
    logic [31:0]               wr_addr_reg, wr_addr_next;
    logic [abm_pkg::BEAT_W-1:0] wr_left_reg, wr_left_next;
    logic [1:0]                wr_step_reg, wr_step_next;
    logic                      accept;

    assign request.ready = clear_done && push_ready;
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        write_open_next = write_open_reg;
        wr_addr_next    = wr_addr_reg;
        wr_left_next    = wr_left_reg;
        wr_step_next    = wr_step_reg;
        push_valid      = 1'b0;
        push_op.op      = abm_pkg::OP_READ;
        push_op.addr    = request.address;
        push_op.data    = request.write_data;
        push_op.count   = abm_pkg::beat_count(request.burst_len);
        push_op.size    = request.beat_size;
        push_op.resp    = 1'b0;
        if (accept)
        begin
            unique case (request.command)
                abm_pkg::CMD_READ_REQ:
                begin
                    push_valid = !write_open_reg;
                end
                abm_pkg::CMD_WRITE_REQ:
                begin
                    if (!write_open_reg)
                    begin
                        write_open_next = 1'b1;
                        wr_addr_next    = request.address;
                        wr_left_next    = abm_pkg::beat_count(request.burst_len);
                        wr_step_next    = request.beat_size;
                    end
                end
                abm_pkg::CMD_WRITE_DAT:
                begin
                    if (write_open_reg)
                    begin
                        push_valid   = 1'b1;
                        push_op.op   = abm_pkg::OP_WRITE;
                        push_op.addr = wr_addr_reg;
                        push_op.resp = (wr_left_reg == abm_pkg::BEAT_W'(1));
                        wr_addr_next = wr_addr_reg + (32'd1 << wr_step_reg);
                        wr_left_next = wr_left_reg - abm_pkg::BEAT_W'(1);
                        if (wr_left_reg == abm_pkg::BEAT_W'(1))
                            write_open_next = 1'b0;
                    end
                end
                default:
                begin
                    // unused command: dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_open_reg <= 1'b0;
            wr_addr_reg    <= '0;
            wr_left_reg    <= '0;
            wr_step_reg    <= '0;
        end
        else
        begin
            write_open_reg <= write_open_next;
            wr_addr_reg    <= wr_addr_next;
            wr_left_reg    <= wr_left_next;
            wr_step_reg    <= wr_step_next;
        end
    end

endmodule

FILE: hw/rtl/abm_queue.sv
// ============================================================================
// abm_queue - operation queue
// Short FIFO between front end and back end.
// ============================================================================
module abm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  abm_pkg::abm_op_t push_op,
    output logic             push_ready,
    output logic             pop_valid,
    output abm_pkg::abm_op_t pop_op,
    input  logic             pop_ready
);

    abm_pkg::abm_op_t            entries_reg [abm_pkg::QUEUE_DEPTH];
    logic [abm_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [abm_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [abm_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        do_push, do_pop;

    assign push_ready = count_reg != abm_pkg::QCNT_W'(abm_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == abm_pkg::QPTR_W'(abm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + abm_pkg::QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == abm_pkg::QPTR_W'(abm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + abm_pkg::QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + abm_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - abm_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/abm_back.sv
// ============================================================================
// abm_back - memory back end
// Word store, clearing pass, read burst sequencer and response register.
// ============================================================================
module abm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  abm_pkg::abm_op_t pop_op,
    output logic             pop_ready,
    abm_out_if.source        response,
    output logic             clear_done
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [31:0] word_store [abm_pkg::MEM_WORDS];

    logic [1:0]                  state_reg, state_next;
    logic [abm_pkg::MEM_AW-1:0]  clr_idx_reg, clr_idx_next;
    logic [31:0]                 rd_addr_reg, rd_addr_next;
    logic [abm_pkg::BEAT_W-1:0]  rd_left_reg, rd_left_next;
    logic [1:0]                  rd_size_reg, rd_size_next;
    logic                        rd_pending_reg, rd_pending_next;
    logic                        rd_oor_reg, rd_last_reg;
    logic [31:0]                 rdata_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_kind_reg;
    logic [31:0]                 out_data_reg;
    logic                        out_last_reg;

    logic                        out_free, take_pend, wresp, rd_en, pop_fire;
    logic                        mem_we;
    logic [abm_pkg::MEM_AW-1:0]  mem_waddr;
    logic [31:0]                 mem_wdata;

    assign clear_done = state_reg != ST_CLEAR;
    assign out_free   = !out_valid_reg || response.ready;
    assign take_pend  = rd_pending_reg && out_free;

    // a write that closes a burst must queue its response behind any pending read beat
    assign pop_ready  = (state_reg == ST_IDLE) &&
                        (pop_op.op == abm_pkg::OP_READ || !pop_op.resp ||
                         (!rd_pending_reg && out_free));
    assign pop_fire   = pop_valid && pop_ready;
    assign wresp      = pop_fire && pop_op.op == abm_pkg::OP_WRITE && pop_op.resp;
    assign rd_en      = (state_reg == ST_READ) && (!rd_pending_reg || out_free);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        rd_addr_next = rd_addr_reg;
        rd_left_next = rd_left_reg;
        rd_size_next = rd_size_reg;
        mem_we       = 1'b0;
        mem_waddr    = clr_idx_reg;
        mem_wdata    = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_idx_next = clr_idx_reg + abm_pkg::MEM_AW'(1);
                if (clr_idx_reg == abm_pkg::MEM_AW'(abm_pkg::MEM_WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pop_fire)
                begin
                    if (pop_op.op == abm_pkg::OP_WRITE)
                    begin
                        mem_we    = abm_pkg::word_in_range(pop_op.addr);
                        mem_waddr = pop_op.addr[abm_pkg::MEM_AW+1:2];
                        mem_wdata = pop_op.data;
                    end
                    else
                    begin
                        rd_addr_next = pop_op.addr;
                        rd_left_next = pop_op.count;
                        rd_size_next = pop_op.size;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_en)
                begin
                    rd_addr_next = rd_addr_reg + (32'd1 << rd_size_reg);
                    rd_left_next = rd_left_reg - abm_pkg::BEAT_W'(1);
                    if (rd_left_reg == abm_pkg::BEAT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_pending_next = rd_pending_reg;
        if (rd_en)
            rd_pending_next = 1'b1;
        else if (take_pend)
            rd_pending_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (take_pend || wresp)
            out_valid_next = 1'b1;
        else if (response.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            word_store[mem_waddr] <= mem_wdata;
        if (rd_en)
            rdata_reg <= word_store[rd_addr_reg[abm_pkg::MEM_AW+1:2]];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_oor_reg  <= !abm_pkg::word_in_range(rd_addr_reg);
            rd_last_reg <= rd_left_reg == abm_pkg::BEAT_W'(1);
        end
        if (take_pend)
        begin
            out_kind_reg <= abm_pkg::KIND_READ_DATA;
            out_data_reg <= rd_oor_reg ? 32'd0 : rdata_reg;
            out_last_reg <= rd_last_reg;
        end
        else if (wresp)
        begin
            out_kind_reg <= abm_pkg::KIND_WRITE_RSP;
            out_data_reg <= 32'd0;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            rd_addr_reg    <= '0;
            rd_left_reg    <= '0;
            rd_size_reg    <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            rd_addr_reg    <= rd_addr_next;
            rd_left_reg    <= rd_left_next;
            rd_size_reg    <= rd_size_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign response.valid     = out_valid_reg;
    assign response.kind      = out_kind_reg;
    assign response.read_data = out_data_reg;
    assign response.last      = out_last_reg;

endmodule

FILE: hw/rtl/axi_burst_memory_slave.sv
// ============================================================================
// axi_burst_memory_slave - word memory behind a simplified burst slave
// Front end, operation queue and memory back end.
// ============================================================================
// Usage:
//   request  : valid/ready channel carrying command, address, burst_len,
//              beat_size and write_data. Read and write requests open a burst;
//              write data words follow a write request.
//   response : valid/ready channel carrying kind, read_data and last.
//   A read request yields burst_len+1 read words (capped at MAX_BEATS), the
//   first passing the operation queue, read sequencer, read data register
//   and response register, then one word per cycle while the receiver takes
//   them; the single read port of the word store sets that rate. Write data
//   words are taken one per cycle while the queue has room; the final word of
//   a burst yields one write response through the queue and response register.
//   Requests during an open write burst, stray data words and unused commands
//   are taken and dropped. After reset the store is cleared one word per cycle,
//   all MEM_WORDS (65536) words, while request.ready stays low.
//   When the receiver stalls, the response register holds its word; the
//   two-entry queue keeps taking requests until it fills.
// ============================================================================
module axi_burst_memory_slave (
    input  logic      clk,
    input  logic      rst_n,
    abm_in_if.sink    request,
    abm_out_if.source response
);

    logic             clear_done;
    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;
    abm_pkg::abm_op_t push_op, pop_op;

    abm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .clear_done (clear_done),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_ready (push_ready)
    );

    abm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op),
        .pop_ready  (pop_ready)
    );

    abm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_op     (pop_op),
        .pop_ready  (pop_ready),
        .response   (response),
        .clear_done (clear_done)
    );

    // front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("operation pushed into full queue");

    // nothing comes out while the store is being cleared
    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> (!response.valid && !request.ready))
        else $error("activity during clearing pass");

    // write responses carry zero data and the last mark
    a_wresp_form: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.kind == abm_pkg::KIND_WRITE_RSP)
            |-> (response.read_data == 32'd0 && response.last))
        else $error("malformed write response");

    // nothing is queued before the clearing pass ends
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !pop_valid)
        else $error("operation queued during clearing pass");

endmodule
